@@ src/pfa_pkg.sv @@
// ----------------------------------------------------------------------------
// Prime field ALU package
// Field widths, opcodes and the status word of the inverse engine.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int FIELD_W = 16;
    localparam int OPC_W   = 2;

    localparam logic [OPC_W-1:0] OP_ADD = 2'd0;
    localparam logic [OPC_W-1:0] OP_MUL = 2'd1;
    localparam logic [OPC_W-1:0] OP_INV = 2'd2;

    localparam logic [FIELD_W-1:0] MODULUS_RESET = 16'd2;

    typedef struct packed {
        logic done;
        logic no_inverse;
    } t_inv_status;

endpackage

@@ src/pfa_inv.sv @@
// ----------------------------------------------------------------------------
// Prime field ALU inverse engine
// Binary extended GCD, one halving or one subtraction per cycle, followed
// by a short correction that brings the coefficient into range.
// ----------------------------------------------------------------------------
module pfa_inv #(
    parameter int WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [WIDTH-1:0]    i_a,
    input  logic [WIDTH-1:0]    i_m,
    output logic [WIDTH-1:0]    o_result,
    output pfa_pkg::t_inv_status o_status
);
    import pfa_pkg::*;

    localparam int SW = WIDTH + 3;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOP = 2'd1;
    localparam logic [1:0] S_FIX  = 2'd2;

    logic [1:0]              r_state, n_state;
    logic [WIDTH-1:0]        r_m, n_m, r_a, n_a;
    logic [WIDTH-1:0]        r_u, n_u, r_v, n_v;
    logic signed [SW-1:0]    r_ca, n_ca, r_cb, n_cb, r_cc, n_cc, r_cd, n_cd;
    logic                    r_done, n_done;
    logic                    r_flag, n_flag;
    logic [WIDTH-1:0]        r_result, n_result;
    logic signed [SW-1:0]    mx, ay;

    assign mx = signed'({3'b000, r_m});
    assign ay = signed'({3'b000, r_a});

    always_comb begin
        n_state  = r_state;
        n_m      = r_m;
        n_a      = r_a;
        n_u      = r_u;
        n_v      = r_v;
        n_ca     = r_ca;
        n_cb     = r_cb;
        n_cc     = r_cc;
        n_cd     = r_cd;
        n_done   = 1'b0;
        n_flag   = r_flag;
        n_result = r_result;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_m  = i_m;
                    n_a  = i_a;
                    n_u  = i_m;
                    n_v  = i_a;
                    n_ca = SW'(1);
                    n_cb = '0;
                    n_cc = '0;
                    n_cd = SW'(1);
                    if (i_a == '0 || (!i_m[0] && !i_a[0])) begin
                        n_done   = 1'b1;
                        n_flag   = 1'b1;
                        n_result = '0;
                    end else begin
                        n_state = S_LOOP;
                    end
                end
            end
            S_LOOP: begin
                priority if (r_u == '0) begin
                    if (r_v == WIDTH'(1)) begin
                        n_state = S_FIX;
                    end else begin
                        n_done   = 1'b1;
                        n_flag   = 1'b1;
                        n_result = '0;
                        n_state  = S_IDLE;
                    end
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                    if (!r_ca[0] && !r_cb[0]) begin
                        n_ca = r_ca >>> 1;
                        n_cb = r_cb >>> 1;
                    end else begin
                        n_ca = (r_ca + ay) >>> 1;
                        n_cb = (r_cb - mx) >>> 1;
                    end
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                    if (!r_cc[0] && !r_cd[0]) begin
                        n_cc = r_cc >>> 1;
                        n_cd = r_cd >>> 1;
                    end else begin
                        n_cc = (r_cc + ay) >>> 1;
                        n_cd = (r_cd - mx) >>> 1;
                    end
                end else if (r_u >= r_v) begin
                    n_u  = r_u - r_v;
                    n_ca = r_ca - r_cc;
                    n_cb = r_cb - r_cd;
                end else begin
                    n_v  = r_v - r_u;
                    n_cc = r_cc - r_ca;
                    n_cd = r_cd - r_cb;
                end
            end
            S_FIX: begin
                priority if (r_cd[SW-1]) begin
                    n_cd = r_cd + mx;
                end else if (r_cd >= mx) begin
                    n_cd = r_cd - mx;
                end else begin
                    n_done   = 1'b1;
                    n_flag   = 1'b0;
                    n_result = r_cd[WIDTH-1:0];
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_m      <= n_m;
        r_a      <= n_a;
        r_u      <= n_u;
        r_v      <= n_v;
        r_ca     <= n_ca;
        r_cb     <= n_cb;
        r_cc     <= n_cc;
        r_cd     <= n_cd;
        r_flag   <= n_flag;
        r_result <= n_result;
    end

    assign o_result            = r_result;
    assign o_status.done       = r_done;
    assign o_status.no_inverse = r_flag;

endmodule

@@ src/prime_field_alu_top.sv @@
// ----------------------------------------------------------------------------
// Prime field ALU
// Modular add, multiply and inverse over a configurable modulus.
//
// Channel   Direction  Handshake                    Word
// cfg       in         i_cfg_we                     i_cfg_wdata (modulus)
// in        in         i_in_valid / o_in_ready      i_opcode, i_operand_a/b
// out       out        o_out_valid / i_out_ready    o_result, o_no_inverse
//
// One word is processed at a time. Both operands are reduced one bit per
// cycle, then add performs a modular addition, multiply runs Horner
// shift-and-add over the bits of B, and inverse runs the GCD loop in the
// inverse engine. The result then passes through the S_OUT state into the
// output register. A stalled output holds the finished result in the
// engine until the output register frees.
// Reset is synchronous and sets the modulus to 2.
// ----------------------------------------------------------------------------
module prime_field_alu_top #(
    parameter int WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pfa_pkg::FIELD_W-1:0]  i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [pfa_pkg::OPC_W-1:0]    i_opcode,
    input  logic [pfa_pkg::FIELD_W-1:0]  i_operand_a,
    input  logic [pfa_pkg::FIELD_W-1:0]  i_operand_b,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [pfa_pkg::FIELD_W-1:0]  o_result,
    output logic                         o_no_inverse
);
    import pfa_pkg::*;

    localparam int CW = $clog2(WIDTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_IST  = 3'd4;
    localparam logic [2:0] S_INV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [OPC_W-1:0]    r_op, n_op;
    logic [WIDTH-1:0]    r_sa, n_sa, r_sb, n_sb;
    logic [WIDTH-1:0]    r_ra, n_ra, r_rb, n_rb;
    logic [WIDTH-1:0]    r_acc, n_acc;
    logic [WIDTH-1:0]    r_res, n_res;
    logic                r_flag, n_flag;
    logic                r_out_valid, n_out_valid;
    logic [FIELD_W-1:0]  r_o_result, n_o_result;
    logic                r_o_flag, n_o_flag;
    logic [FIELD_W-1:0]  r_modulus;

    logic [WIDTH-1:0]    mw, m_eff;
    logic [WIDTH:0]      m_ext;
    logic [WIDTH:0]      red_a, red_b, dbl, sum_ab, mac;
    logic [WIDTH-1:0]    red_a_r, red_b_r, dbl_r, sum_ab_r, mac_r;
    logic                inv_start;
    logic [WIDTH-1:0]    inv_result;
    t_inv_status         inv_status;

    assign mw    = WIDTH'(r_modulus);
    assign m_eff = (mw < WIDTH'(2)) ? WIDTH'(1) : mw;
    assign m_ext = {1'b0, m_eff};

    // Bit-serial remainder: shift in the next operand bit, subtract once.
    assign red_a   = {r_ra, r_sa[WIDTH-1]};
    assign red_b   = {r_rb, r_sb[WIDTH-1]};
    assign red_a_r = (red_a >= m_ext) ? WIDTH'(red_a - m_ext) : red_a[WIDTH-1:0];
    assign red_b_r = (red_b >= m_ext) ? WIDTH'(red_b - m_ext) : red_b[WIDTH-1:0];

    assign sum_ab   = {1'b0, r_ra} + {1'b0, r_rb};
    assign sum_ab_r = (sum_ab >= m_ext) ? WIDTH'(sum_ab - m_ext) : sum_ab[WIDTH-1:0];

    // Horner step of the product: double, then add operand A on a set bit of B.
    assign dbl   = {r_acc, 1'b0};
    assign dbl_r = (dbl >= m_ext) ? WIDTH'(dbl - m_ext) : dbl[WIDTH-1:0];
    assign mac   = {1'b0, dbl_r} + (r_sb[WIDTH-1] ? {1'b0, r_ra} : '0);
    assign mac_r = (mac >= m_ext) ? WIDTH'(mac - m_ext) : mac[WIDTH-1:0];

    assign inv_start = (r_state == S_IST);

    pfa_inv #(
        .WIDTH (WIDTH)
    ) u_inv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (inv_start),
        .i_a      (r_ra),
        .i_m      (m_eff),
        .o_result (inv_result),
        .o_status (inv_status)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_op        = r_op;
        n_sa        = r_sa;
        n_sb        = r_sb;
        n_ra        = r_ra;
        n_rb        = r_rb;
        n_acc       = r_acc;
        n_res       = r_res;
        n_flag      = r_flag;
        n_o_result  = r_o_result;
        n_o_flag    = r_o_flag;
        n_out_valid = r_out_valid & ~i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_opcode;
                    n_sa    = WIDTH'(i_operand_a);
                    n_sb    = WIDTH'(i_operand_b);
                    n_ra    = '0;
                    n_rb    = '0;
                    n_cnt   = CW'(WIDTH - 1);
                    n_state = S_RED;
                end
            end
            S_RED: begin
                n_ra  = red_a_r;
                n_rb  = red_b_r;
                n_sa  = r_sa << 1;
                n_sb  = r_sb << 1;
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    unique case (r_op)
                        OP_ADD: begin
                            n_state = S_ADD;
                        end
                        OP_MUL: begin
                            n_sb    = red_b_r;
                            n_acc   = '0;
                            n_cnt   = CW'(WIDTH - 1);
                            n_state = S_MUL;
                        end
                        OP_INV: begin
                            n_state = S_IST;
                        end
                        default: begin
                            n_res   = '0;
                            n_flag  = 1'b0;
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_ADD: begin
                n_res   = sum_ab_r;
                n_flag  = 1'b0;
                n_state = S_OUT;
            end
            S_MUL: begin
                n_acc = mac_r;
                n_sb  = r_sb << 1;
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_res   = mac_r;
                    n_flag  = 1'b0;
                    n_state = S_OUT;
                end
            end
            S_IST: begin
                n_state = S_INV;
            end
            S_INV: begin
                if (inv_status.done) begin
                    n_res   = inv_result;
                    n_flag  = inv_status.no_inverse;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_o_result  = FIELD_W'(r_res);
                    n_o_flag    = r_flag;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_modulus   <= MODULUS_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
        end
        r_cnt      <= n_cnt;
        r_op       <= n_op;
        r_sa       <= n_sa;
        r_sb       <= n_sb;
        r_ra       <= n_ra;
        r_rb       <= n_rb;
        r_acc      <= n_acc;
        r_res      <= n_res;
        r_flag     <= n_flag;
        r_o_result <= n_o_result;
        r_o_flag   <= n_o_flag;
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_result     = r_o_result;
    assign o_no_inverse = r_o_flag;

endmodule
